[src/sfb_pkg.sv]
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types and constants for the serial API frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_PAYLOAD = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [15:0] FCS_INIT  = 16'hFFFF;
    localparam logic [15:0] FCS_POLY  = 16'h8408;

    // One unit of work for the byte sequencer.
    typedef struct packed {
        logic       is_start;     // full header, else one payload byte
        logic       trailer;      // close the frame after this job
        logic [7:0] ctrl;
        logic [7:0] ptype;
        logic [7:0] seq;
        logic [7:0] data;         // length byte on start, payload byte otherwise
    } t_job;

endpackage

[src/sfb_front.sv]
// ----------------------------------------------------------------------------
// sfb_front
// Request decode: tracks the open frame, byte count and sequence number and
// turns each request into a job for the byte sequencer.
// ----------------------------------------------------------------------------
module sfb_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_control_byte,
    input  logic [7:0]        i_packet_type,
    input  logic [7:0]        i_payload_length,
    input  logic [7:0]        i_payload_byte,
    output logic              o_push,
    output sfb_pkg::t_job     o_job
);
    import sfb_pkg::*;

    logic       r_frame_open, n_frame_open;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_seq, n_seq;

    always_comb begin
        n_frame_open = r_frame_open;
        n_bytes_left = r_bytes_left;
        n_seq        = r_seq;
        o_push       = 1'b0;
        o_job.is_start = 1'b0;
        o_job.trailer  = 1'b0;
        o_job.ctrl     = i_control_byte;
        o_job.ptype    = i_packet_type;
        o_job.seq      = r_seq;
        o_job.data     = i_payload_byte;
        if (i_accept) begin
            case (i_command)
                CMD_START: begin
                    o_push         = 1'b1;
                    o_job.is_start = 1'b1;
                    o_job.data     = i_payload_length;
                    o_job.trailer  = (i_payload_length == 8'd0);
                    n_seq          = r_seq + 8'd1;
                    n_frame_open   = (i_payload_length != 8'd0);
                    n_bytes_left   = i_payload_length;
                end
                CMD_PAYLOAD: begin
                    if (r_frame_open) begin
                        o_push        = 1'b1;
                        o_job.trailer = (r_bytes_left == 8'd1);
                        n_bytes_left  = r_bytes_left - 8'd1;
                        if (r_bytes_left == 8'd1) begin
                            n_frame_open = 1'b0;
                        end
                    end
                end
                CMD_CLEAR: begin
                    n_seq = 8'd0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_bytes_left <= 8'd0;
            r_seq        <= 8'd0;
        end else begin
            r_frame_open <= n_frame_open;
            r_bytes_left <= n_bytes_left;
            r_seq        <= n_seq;
        end
    end

endmodule

[src/sfb_queue.sv]
// ----------------------------------------------------------------------------
// sfb_queue
// Small job queue between request decode and the byte sequencer.
// ----------------------------------------------------------------------------
module sfb_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sfb_pkg::t_job     i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output sfb_pkg::t_job     o_job
);
    import sfb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job           r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[src/sfb_back.sv]
// ----------------------------------------------------------------------------
// sfb_back
// Byte sequencer: walks each job one byte per cycle unless stalled, folds
// header and payload bytes into the FCS and appends the trailer when asked.
// ----------------------------------------------------------------------------
module sfb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  sfb_pkg::t_job     i_q_job,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [7:0]        o_tx_byte,
    output logic              o_last_of_run,
    output logic              o_end_of_frame
);
    import sfb_pkg::*;

    typedef enum logic [7:0] {
        S_FLAG   = 8'b0000_0001,
        S_CTRL   = 8'b0000_0010,
        S_TYPE   = 8'b0000_0100,
        S_SEQ    = 8'b0000_1000,
        S_LEN    = 8'b0001_0000,
        S_FCS_LO = 8'b0010_0000,
        S_FCS_HI = 8'b0100_0000,
        S_CLOSE  = 8'b1000_0000
    } t_step;

    function automatic logic [15:0] fcs_fold(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] acc;
        acc = fcs ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            acc = acc[0] ? ((acc >> 1) ^ FCS_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    t_job        r_job;
    t_step       r_state, n_state;
    logic        r_busy;
    logic [15:0] r_fcs, n_fcs;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last, r_out_eof;

    logic        adv, last, load;
    logic [7:0]  cur_byte;
    logic [15:0] fcs_x;

    assign fcs_x = r_fcs ^ FCS_INIT;
    // output slot frees up this cycle if empty or being drained
    assign adv   = r_busy && (!r_out_valid || i_pop);
    assign last  = ((r_state == S_LEN) && !r_job.trailer) || (r_state == S_CLOSE);
    assign load  = (!r_busy || (adv && last)) && !i_q_empty;
    assign o_q_pop = load;

    always_comb begin
        n_fcs    = r_fcs;
        cur_byte = FLAG_BYTE;
        n_state  = S_FLAG;
        case (r_state)
            S_FLAG: begin
                cur_byte = FLAG_BYTE;
                n_fcs    = FCS_INIT;
                n_state  = S_CTRL;
            end
            S_CTRL: begin
                cur_byte = r_job.ctrl;
                n_fcs    = fcs_fold(r_fcs, cur_byte);
                n_state  = S_TYPE;
            end
            S_TYPE: begin
                cur_byte = r_job.ptype;
                n_fcs    = fcs_fold(r_fcs, cur_byte);
                n_state  = S_SEQ;
            end
            S_SEQ: begin
                cur_byte = r_job.seq;
                n_fcs    = fcs_fold(r_fcs, cur_byte);
                n_state  = S_LEN;
            end
            S_LEN: begin
                cur_byte = r_job.data;
                n_fcs    = fcs_fold(r_fcs, cur_byte);
                n_state  = S_FCS_LO;
            end
            S_FCS_LO: begin
                cur_byte = fcs_x[7:0];
                n_state  = S_FCS_HI;
            end
            S_FCS_HI: begin
                cur_byte = fcs_x[15:8];
                n_state  = S_CLOSE;
            end
            S_CLOSE: begin
                cur_byte = FLAG_BYTE;
                n_fcs    = FCS_INIT;
                n_state  = S_FLAG;
            end
            default: begin
                cur_byte = FLAG_BYTE;
                n_state  = S_FLAG;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_job;
        end
        if (adv) begin
            r_out_byte <= cur_byte;
            r_out_last <= last;
            r_out_eof  <= (r_state == S_CLOSE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_state     <= S_FLAG;
            r_fcs       <= FCS_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_fcs <= n_fcs;
            end
            if (load) begin
                r_busy  <= 1'b1;
                // payload jobs enter at the data byte
                r_state <= i_q_job.is_start ? S_FLAG : S_LEN;
            end else if (adv && last) begin
                r_busy <= 1'b0;
            end else if (adv) begin
                r_state <= n_state;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_tx_byte      = r_out_byte;
    assign o_last_of_run  = r_out_last;
    assign o_end_of_frame = r_out_eof;

endmodule

[src/serial_api_frame_builder_fcs16.sv]
// ----------------------------------------------------------------------------
// serial_api_frame_builder_fcs16
// Serial API frame builder with FCS-16 trailer.
//
//  channel   handshake         payload
//  -------   ---------------   ---------------------------------------------
//  request   push / full       command, control_byte, packet_type,
//                              payload_length, payload_byte
//  result    pop / empty       tx_byte, last_of_run, end_of_frame
//
// The byte sequencer emits one byte per cycle unless the output is stalled:
// a start gives 5 bytes (8 if zero-length), a payload byte 1 (4 if last).
// Requests are taken every cycle while the job queue (QUEUE_DEPTH) has room.
// Clear, stray payload and unused commands emit nothing.
// Synchronous reset empties the queue and the output register.
// A stalled pop holds the output byte; the sequencer then backs up the queue.
// ----------------------------------------------------------------------------
module serial_api_frame_builder_fcs16 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_control_byte,
    input  logic [7:0]  i_packet_type,
    input  logic [7:0]  i_payload_length,
    input  logic [7:0]  i_payload_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_of_run,
    output logic        o_end_of_frame
);
    import sfb_pkg::*;

    logic  accept;
    logic  fr_push;
    t_job  fr_job;
    logic  q_empty, q_pop;
    t_job  q_job;

    assign accept = push && !full;

    sfb_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_command        (i_command),
        .i_control_byte   (i_control_byte),
        .i_packet_type    (i_packet_type),
        .i_payload_length (i_payload_length),
        .i_payload_byte   (i_payload_byte),
        .o_push           (fr_push),
        .o_job            (fr_job)
    );

    sfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_job   (fr_job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    sfb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_job        (q_job),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_tx_byte      (o_tx_byte),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

[src/sfb_checker.sv]
// ----------------------------------------------------------------------------
// sfb_checker
// Port-level checks for the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
module sfb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_full,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_last_of_run,
    input  logic        i_end_of_frame
);
    import sfb_pkg::*;

    // reset leaves nothing to read and room to write
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> i_empty && !i_full)
        else $error("not idle after reset");

    // a closing flag is always the final byte of its request
    a_close_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && i_end_of_frame) |-> (i_tx_byte == FLAG_BYTE) && i_last_of_run)
        else $error("bad closing flag");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> !i_empty && $stable(i_tx_byte) && $stable(i_last_of_run))
        else $error("output changed while stalled");

endmodule

bind serial_api_frame_builder_fcs16 sfb_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_full         (full),
    .i_empty        (empty),
    .i_pop          (pop),
    .i_tx_byte      (o_tx_byte),
    .i_last_of_run  (o_last_of_run),
    .i_end_of_frame (o_end_of_frame)
);
